// ----- src/dsrt_pkg.sv -----
// ----------------------------------------------------------------------------
// dsrt_pkg
// constants, widths and command codes for the sample rate time constant core
// ----------------------------------------------------------------------------
package dsrt_pkg;

  localparam int REQ_W   = 20;
  localparam int RATE_W  = 16;
  localparam int SRATE_W = 17;
  localparam int ACT_W   = 17;
  localparam int VER_W   = 16;
  localparam int CFG_W   = 16;

  localparam int NUM1_W  = 28;
  localparam int QUO1_W  = 14;
  localparam int NUM2_W  = 20;
  localparam int DEN2_W  = 9;
  localparam int QUO2_W  = 17;

  localparam logic [0:0] REG_SIXTEEN = 1'd0;
  localparam logic [0:0] REG_VERSION = 1'd1;

  localparam logic [7:0] CMD_TCONST   = 8'h40;
  localparam logic [7:0] CMD_RATE_PLAY = 8'h41;
  localparam logic [7:0] CMD_RATE_REC = 8'h42;

  localparam logic [REQ_W-1:0] DIRECT_MIN = REQ_W'(5000);
  localparam logic [REQ_W-1:0] DIRECT_MAX = REQ_W'(45000);
  localparam logic [REQ_W-1:0] OLD_MIN    = REQ_W'(4000);
  localparam logic [REQ_W-1:0] OLD_MAX    = REQ_W'(45000);
  localparam logic [REQ_W-1:0] LOW_PLAY_MAX = REQ_W'(22050);
  localparam logic [REQ_W-1:0] LOW_REC_MAX  = REQ_W'(13000);
  localparam logic [REQ_W-1:0] MID_REC_MAX  = REQ_W'(15000);

  localparam logic [VER_W-1:0] VER_LOW   = 16'h0200;
  localparam logic [VER_W-1:0] VER_PRO   = 16'h0300;
  localparam logic [VER_W-1:0] VER_RESET = 16'h0201;

  localparam logic [SRATE_W-1:0] HS_THRESHOLD = SRATE_W'(22050);
  localparam logic [NUM1_W-1:0]  HS_CLOCK = NUM1_W'(256000000);
  localparam logic [NUM1_W-1:0]  LS_CLOCK = NUM1_W'(1000000);
  localparam logic [NUM2_W-1:0]  BACK_CLOCK = NUM2_W'(1000000);

  typedef struct packed {
    logic              direct;
    logic              play;
    logic              stereo;
    logic              hs;
    logic [RATE_W-1:0] drate;
  } side1_t;

  typedef struct packed {
    side1_t     s;
    logic [7:0] tc;
  } side2_t;

endpackage

// ----- src/dsp_sample_rate_time_constant_core.sv -----
// ----------------------------------------------------------------------------
// dsp_sample_rate_time_constant_core
// turns a requested sample rate into dsp command bytes and the realised rate
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | content
//  in_     | input     | in_valid/in_stall   | requested_rate, playback, stereo
//  out_    | output    | out_valid/out_stall | actual_rate, command and args
//  cfg_    | input     | cfg_we              | is_sixteen_bit_card, board_version
//
//  one transaction per cycle while no stall holds the pipeline; stages: input
//  stage, 14 divider stages, two stages forming the time constant, 17 divider
//  stages, output stage; the two dividers resolve one quotient bit per stage
//  synchronous reset clears valid bits and the sixteen-bit flag, and sets the board version to 0x0201
//  a stall holds each full stage whose next stage is held; empty stages keep filling behind it
module dsp_sample_rate_time_constant_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [dsrt_pkg::REQ_W-1:0] in_requested_rate,
  input  logic                       in_playback,
  input  logic                       in_stereo,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [dsrt_pkg::ACT_W-1:0] out_actual_rate,
  output logic [7:0]                 out_dsp_command,
  output logic [7:0]                 out_arg_high,
  output logic [7:0]                 out_arg_low,
  output logic [1:0]                 out_arg_count,
  output logic                       out_high_speed,
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_index,
  input  logic [dsrt_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int SW1 = $bits(dsrt_pkg::side1_t);
  localparam int SW2 = $bits(dsrt_pkg::side2_t);

  logic                       sixteen_r;
  logic [dsrt_pkg::VER_W-1:0] version_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sixteen_r <= 1'b0;
      version_r <= dsrt_pkg::VER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dsrt_pkg::REG_SIXTEEN: sixteen_r <= cfg_wdata[0];
        dsrt_pkg::REG_VERSION: version_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input stage: limits, stereo doubling, first numerator
  logic [dsrt_pkg::REQ_W-1:0]   maxr, drate_w, orate_w;
  logic [dsrt_pkg::SRATE_W-1:0] srate;
  logic                         hs_w;
  logic [dsrt_pkg::NUM1_W-1:0]  num1_nxt;
  dsrt_pkg::side1_t             side1_nxt;

  always_comb begin
    maxr = dsrt_pkg::OLD_MAX;
    if (version_r <= dsrt_pkg::VER_LOW) begin
      maxr = dsrt_pkg::LOW_PLAY_MAX;
    end
    if (!in_playback) begin
      if (version_r <= dsrt_pkg::VER_LOW) begin
        maxr = dsrt_pkg::LOW_REC_MAX;
      end else if (version_r < dsrt_pkg::VER_PRO) begin
        maxr = dsrt_pkg::MID_REC_MAX;
      end
    end
    priority if (in_requested_rate < dsrt_pkg::DIRECT_MIN) drate_w = dsrt_pkg::DIRECT_MIN;
    else if (in_requested_rate > dsrt_pkg::DIRECT_MAX) drate_w = dsrt_pkg::DIRECT_MAX;
    else drate_w = in_requested_rate;
    priority if (in_requested_rate < dsrt_pkg::OLD_MIN) orate_w = dsrt_pkg::OLD_MIN;
    else if (in_requested_rate > maxr) orate_w = maxr;
    else orate_w = in_requested_rate;
    srate = in_stereo ? {orate_w[dsrt_pkg::RATE_W-1:0], 1'b0}
                      : {1'b0, orate_w[dsrt_pkg::RATE_W-1:0]};
    hs_w = srate > dsrt_pkg::HS_THRESHOLD;
    num1_nxt = (hs_w ? dsrt_pkg::HS_CLOCK : dsrt_pkg::LS_CLOCK)
               + dsrt_pkg::NUM1_W'(srate >> 1);
    side1_nxt.direct = sixteen_r;
    side1_nxt.play   = in_playback;
    side1_nxt.stereo = in_stereo;
    side1_nxt.hs     = hs_w;
    side1_nxt.drate  = drate_w[dsrt_pkg::RATE_W-1:0];
  end

  logic                         a_v_r, a_rdy;
  logic [dsrt_pkg::NUM1_W-1:0]  a_num_r;
  logic [dsrt_pkg::SRATE_W-1:0] a_den_r;
  dsrt_pkg::side1_t             a_side_r;
  logic                         d1_in_ready;

  assign a_rdy    = !a_v_r || d1_in_ready;
  assign in_stall = !a_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (a_rdy) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy) begin
      a_num_r  <= num1_nxt;
      a_den_r  <= srate;
      a_side_r <= side1_nxt;
    end
  end

  logic                        d1_v, m1_rdy;
  logic [dsrt_pkg::QUO1_W-1:0] d1_q;
  logic [SW1-1:0]              d1_side;

  dsrt_div #(
    .NW(dsrt_pkg::NUM1_W), .DW(dsrt_pkg::SRATE_W), .QW(dsrt_pkg::QUO1_W), .SW(SW1)
  ) u_div1 (
    .clk(clk), .rst_n(rst_n),
    .in_valid(a_v_r), .in_ready(d1_in_ready),
    .in_num(a_num_r), .in_den(a_den_r), .in_side(a_side_r),
    .out_valid(d1_v), .out_ready(m1_rdy),
    .out_quo(d1_q), .out_side(d1_side)
  );

  // time constant and back divisor
  dsrt_pkg::side1_t            s1;
  logic [15:0]                 negq;
  dsrt_pkg::side2_t            side2_nxt;
  logic [dsrt_pkg::DEN2_W-1:0] d_nxt;

  always_comb begin
    s1 = dsrt_pkg::side1_t'(d1_side);
    negq = 16'd0 - 16'(d1_q);
    side2_nxt.s  = s1;
    side2_nxt.tc = s1.hs ? negq[15:8] : negq[7:0];
    d_nxt = dsrt_pkg::DEN2_W'(256) - dsrt_pkg::DEN2_W'(side2_nxt.tc);
  end

  logic                        m1_v_r, m2_v_r, m2_rdy, d2_in_ready;
  logic [dsrt_pkg::DEN2_W-1:0] m1_d_r, m2_d_r;
  dsrt_pkg::side2_t            m1_side_r, m2_side_r;
  logic [dsrt_pkg::NUM2_W-1:0] m2_num_r;

  assign m1_rdy = !m1_v_r || m2_rdy;
  assign m2_rdy = !m2_v_r || d2_in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
    end else begin
      if (m1_rdy) m1_v_r <= d1_v;
      if (m2_rdy) m2_v_r <= m1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (m1_rdy) begin
      m1_d_r    <= d_nxt;
      m1_side_r <= side2_nxt;
    end
    if (m2_rdy) begin
      m2_d_r    <= m1_d_r;
      m2_num_r  <= dsrt_pkg::BACK_CLOCK + dsrt_pkg::NUM2_W'(m1_d_r >> 1);
      m2_side_r <= m1_side_r;
    end
  end

  logic                        d2_v, o_rdy;
  logic [dsrt_pkg::QUO2_W-1:0] d2_q;
  logic [SW2-1:0]              d2_side;

  dsrt_div #(
    .NW(dsrt_pkg::NUM2_W), .DW(dsrt_pkg::DEN2_W), .QW(dsrt_pkg::QUO2_W), .SW(SW2)
  ) u_div2 (
    .clk(clk), .rst_n(rst_n),
    .in_valid(m2_v_r), .in_ready(d2_in_ready),
    .in_num(m2_num_r), .in_den(m2_d_r), .in_side(m2_side_r),
    .out_valid(d2_v), .out_ready(o_rdy),
    .out_quo(d2_q), .out_side(d2_side)
  );

  // output stage
  dsrt_pkg::side2_t           s2;
  logic [dsrt_pkg::ACT_W-1:0] rate_nxt;
  logic [7:0]                 cmd_nxt, ahi_nxt, alo_nxt;
  logic [1:0]                 cnt_nxt;
  logic                       hs_nxt;

  always_comb begin
    s2 = dsrt_pkg::side2_t'(d2_side);
    if (s2.s.direct) begin
      rate_nxt = dsrt_pkg::ACT_W'(s2.s.drate);
      cmd_nxt  = s2.s.play ? dsrt_pkg::CMD_RATE_PLAY : dsrt_pkg::CMD_RATE_REC;
      ahi_nxt  = s2.s.drate[15:8];
      alo_nxt  = s2.s.drate[7:0];
      cnt_nxt  = 2'd2;
      hs_nxt   = 1'b0;
    end else begin
      rate_nxt = s2.s.stereo ? (d2_q >> 1) : d2_q;
      cmd_nxt  = dsrt_pkg::CMD_TCONST;
      ahi_nxt  = 8'd0;
      alo_nxt  = s2.tc;
      cnt_nxt  = 2'd1;
      hs_nxt   = s2.s.hs;
    end
  end

  logic                       o_v_r;
  logic [dsrt_pkg::ACT_W-1:0] o_rate_r;
  logic [7:0]                 o_cmd_r, o_ahi_r, o_alo_r;
  logic [1:0]                 o_cnt_r;
  logic                       o_hs_r;

  assign o_rdy = !o_v_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (o_rdy) begin
      o_v_r <= d2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (o_rdy) begin
      o_rate_r <= rate_nxt;
      o_cmd_r  <= cmd_nxt;
      o_ahi_r  <= ahi_nxt;
      o_alo_r  <= alo_nxt;
      o_cnt_r  <= cnt_nxt;
      o_hs_r   <= hs_nxt;
    end
  end

  assign out_valid       = o_v_r;
  assign out_actual_rate = o_rate_r;
  assign out_dsp_command = o_cmd_r;
  assign out_arg_high    = o_ahi_r;
  assign out_arg_low     = o_alo_r;
  assign out_arg_count   = o_cnt_r;
  assign out_high_speed  = o_hs_r;

endmodule

// ----- src/dsrt_div.sv -----
// ----------------------------------------------------------------------------
// dsrt_div
// pipelined restoring divider, one quotient bit per stage, with sideband
// ----------------------------------------------------------------------------
module dsrt_div #(
  parameter int NW = 28,
  parameter int DW = 17,
  parameter int QW = 14,
  parameter int SW = 20
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [QW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  localparam int TW = (NW > DW + QW) ? NW : DW + QW;

  logic          v_r    [QW];
  logic [NW-1:0] rem_r  [QW];
  logic [DW-1:0] den_r  [QW];
  logic [QW-1:0] quo_r  [QW];
  logic [SW-1:0] side_r [QW];
  logic [QW:0]   rdy;

  assign rdy[QW] = out_ready;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          vin;
    logic [NW-1:0] rin;
    logic [DW-1:0] din;
    logic [QW-1:0] qin;
    logic [SW-1:0] sin;
    logic [TW-1:0] trial;
    logic [TW-1:0] rext;
    logic          take;

    if (k == 0) begin : g_first
      assign vin = in_valid;
      assign rin = in_num;
      assign din = in_den;
      assign qin = '0;
      assign sin = in_side;
    end else begin : g_next
      assign vin = v_r[k-1];
      assign rin = rem_r[k-1];
      assign din = den_r[k-1];
      assign qin = quo_r[k-1];
      assign sin = side_r[k-1];
    end

    assign trial = TW'(din) << (QW - 1 - k);
    assign rext  = TW'(rin);
    assign take  = rext >= trial;
    assign rdy[k] = !v_r[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        rem_r[k]  <= take ? NW'(rext - trial) : rin;
        den_r[k]  <= din;
        quo_r[k]  <= qin | (QW'(take) << (QW - 1 - k));
        side_r[k] <= sin;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[QW-1];
  assign out_quo   = quo_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

// ----- bench/tb_dsp_sample_rate_time_constant_core.sv -----
// ----------------------------------------------------------------------------
// tb_dsp_sample_rate_time_constant_core
// drives rate requests through the core under several card settings and
// checks every command, argument and realised rate against a local predictor
// ----------------------------------------------------------------------------
module tb_dsp_sample_rate_time_constant_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [dsrt_pkg::ACT_W-1:0] rate;
    logic [7:0]                 cmd;
    logic [7:0]                 ahi;
    logic [7:0]                 alo;
    logic [1:0]                 cnt;
    logic                       hs;
  } rate_setting_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [dsrt_pkg::REQ_W-1:0] in_requested_rate = '0;
  logic in_playback = 1'b0;
  logic in_stereo = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [dsrt_pkg::ACT_W-1:0] out_actual_rate;
  logic [7:0] out_dsp_command;
  logic [7:0] out_arg_high;
  logic [7:0] out_arg_low;
  logic [1:0] out_arg_count;
  logic out_high_speed;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = dsrt_pkg::REG_SIXTEEN;
  logic [dsrt_pkg::CFG_W-1:0] cfg_wdata = '0;

  logic sixteen_mode;
  logic [dsrt_pkg::VER_W-1:0] version_word;
  rate_setting_t pending_settings[$];
  int send_idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int sent = 0;
  int checked = 0;
  int quiet_cycles = 0;

  dsp_sample_rate_time_constant_core dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic rate_setting_t predict_setting(logic [dsrt_pkg::REQ_W-1:0] req,
                                                    logic play, logic st);
    rate_setting_t r;
    longint unsigned rate, maxr, q, tc, dv;
    if (sixteen_mode) begin
      rate = req < 5000 ? 5000 : (req > 45000 ? 45000 : req);
      r.rate = rate[dsrt_pkg::ACT_W-1:0];
      r.cmd = play ? dsrt_pkg::CMD_RATE_PLAY : dsrt_pkg::CMD_RATE_REC;
      r.ahi = rate[15:8];
      r.alo = rate[7:0];
      r.cnt = 2'd2;
      r.hs = 1'b0;
    end else begin
      maxr = 45000;
      if (version_word <= dsrt_pkg::VER_LOW) maxr = 22050;
      if (!play) begin
        if (version_word <= dsrt_pkg::VER_LOW) maxr = 13000;
        else if (version_word < dsrt_pkg::VER_PRO) maxr = 15000;
      end
      rate = req < 4000 ? 4000 : (req > maxr ? maxr : req);
      if (st) rate = rate << 1;
      if (rate > 22050) begin
        q = (256000000 + rate / 2) / rate;
        tc = ((65536 - q) >> 8) & 8'hff;
        dv = 65536 - (tc << 8);
        rate = (256000000 + dv / 2) / dv;
        r.hs = 1'b1;
      end else begin
        q = (1000000 + rate / 2) / rate;
        tc = (256 - q) & 8'hff;
        dv = 256 - tc;
        rate = (1000000 + dv / 2) / dv;
        r.hs = 1'b0;
      end
      if (st) rate = rate >> 1;
      r.rate = rate[dsrt_pkg::ACT_W-1:0];
      r.cmd = dsrt_pkg::CMD_TCONST;
      r.ahi = 8'h00;
      r.alo = tc[7:0];
      r.cnt = 2'd1;
    end
    return r;
  endfunction

  // receiver stall and result checking
  always @(posedge clk) begin
    if (out_valid && !out_stall && rst_n) begin
      if (pending_settings.size() == 0) begin
        $error("unexpected result transaction, rate %0d", out_actual_rate);
        errors++;
      end else begin
        rate_setting_t e;
        e = pending_settings.pop_front();
        if (out_actual_rate !== e.rate) begin
          $error("actual_rate exp %0d got %0d", e.rate, out_actual_rate); errors++;
        end
        if (out_dsp_command !== e.cmd) begin
          $error("dsp_command exp %0h got %0h", e.cmd, out_dsp_command); errors++;
        end
        if (out_arg_high !== e.ahi) begin
          $error("arg_high exp %0h got %0h", e.ahi, out_arg_high); errors++;
        end
        if (out_arg_low !== e.alo) begin
          $error("arg_low exp %0h got %0h", e.alo, out_arg_low); errors++;
        end
        if (out_arg_count !== e.cnt) begin
          $error("arg_count exp %0d got %0d", e.cnt, out_arg_count); errors++;
        end
        if (out_high_speed !== e.hs) begin
          $error("high_speed exp %0d got %0d", e.hs, out_high_speed); errors++;
        end
        checked++;
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // watchdog on accepted transactions
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_request(logic [dsrt_pkg::REQ_W-1:0] req, logic play, logic st);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_requested_rate <= req;
    in_playback <= play;
    in_stereo <= st;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_settings.push_back(predict_setting(req, play, st));
    sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_settings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [dsrt_pkg::CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == dsrt_pkg::REG_SIXTEEN) sixteen_mode = val[0];
    else version_word = val;
    @(posedge clk);
  endtask

  function automatic logic [dsrt_pkg::REQ_W-1:0] random_rate();
    case ($urandom_range(5))
      0: return dsrt_pkg::REQ_W'($urandom_range(6000));
      1: return dsrt_pkg::REQ_W'($urandom_range(46000, 3000));
      2: return dsrt_pkg::REQ_W'($urandom_range(24000, 10000));
      3: return dsrt_pkg::REQ_W'($urandom);
      4: return dsrt_pkg::REQ_W'($urandom_range(12000, 11000));
      default: return dsrt_pkg::REQ_W'($urandom_range(20000, 1000));
    endcase
  endfunction

  task automatic test_directed_edges();
    logic [dsrt_pkg::REQ_W-1:0] rates[8] = '{20'd0, 20'd3999, 20'd4000, 20'd5000,
                                             20'd13000, 20'd22050, 20'd45000, 20'hfffff};
    foreach (rates[i]) send_request(rates[i], i[0], i[1]);
    send_request(20'd15000, 1'b0, 1'b0);
    send_request(20'd11025, 1'b1, 1'b1);
    send_request(20'd22051, 1'b1, 1'b0);
    wait_drained();
  endtask

  task automatic test_card_settings();
    logic [dsrt_pkg::CFG_W-1:0] versions[6] = '{16'h0000, 16'h0200, 16'h0201,
                                                16'h02ff, 16'h0300, 16'hffff};
    foreach (versions[v]) begin
      write_reg(dsrt_pkg::REG_VERSION, versions[v]);
      for (int m = 0; m < 2; m++) begin
        write_reg(dsrt_pkg::REG_SIXTEEN, (m == 1) ? 16'hffff : 16'hfffe);
        for (int k = 0; k < 4; k++)
          send_request(k[0] ? 20'd45000 : 20'd4000, k[1], ~k[0]);
        wait_drained();
      end
    end
  endtask

  task automatic random_phase(int n, int idle, int stall);
    logic [dsrt_pkg::CFG_W-1:0] ver;
    send_idle_pct = idle;
    stall_pct = stall;
    if ($urandom_range(3) == 0) ver = dsrt_pkg::CFG_W'($urandom);
    else ver = dsrt_pkg::CFG_W'($urandom_range(16'h0310, 16'h01f0));
    write_reg(dsrt_pkg::REG_SIXTEEN, dsrt_pkg::CFG_W'($urandom_range(1)));
    write_reg(dsrt_pkg::REG_VERSION, ver);
    repeat (n) send_request(random_rate(), 1'($urandom_range(1)), 1'($urandom_range(1)));
    wait_drained();
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 4; p++) begin
      random_phase(70, 0, 0);
      random_phase(50, 87, 0);
      random_phase(50, 0, 87);
      random_phase(70, 19, 19);
    end
    stall_pct = 0;
    send_idle_pct = 0;
  endtask

  initial begin
    sixteen_mode = 1'b0;
    version_word = dsrt_pkg::VER_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_edges();
    test_card_settings();
    test_random_traffic();
    wait_drained();
    $display("covered %0d rate requests, %0d results checked, both card modes", sent, checked);
    $display("board versions from 0x0000 to 0xffff, with sender gaps and receiver stalls");
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- dsp_sample_rate_time_constant_core.f -----
src/dsrt_pkg.sv
src/dsrt_div.sv
src/dsp_sample_rate_time_constant_core.sv
bench/tb_dsp_sample_rate_time_constant_core.sv
